### hw/rtl/chkv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chkv_pkg: shared types and constants
// Sizes, operation and status codes, and the request record passed from the
// hash front end to the bucket back end.
// ----------------------------------------------------------------------------
package chkv_pkg;
  localparam int unsigned Buckets     = 64;
  localparam int unsigned SlotsPerBkt = 4;
  localparam int unsigned TotalSlots  = Buckets * SlotsPerBkt;
  localparam int unsigned BktW  = (Buckets > 1) ? $clog2(Buckets) : 1;
  localparam int unsigned SlotW = (SlotsPerBkt > 1) ? $clog2(SlotsPerBkt) : 1;
  localparam int unsigned AddrW = (TotalSlots > 1) ? $clog2(TotalSlots) : 1;
  localparam int unsigned CntW  = 9;
  localparam int unsigned QDepth = 2;
  localparam logic [63:0] JumpMul = 64'd2862933555777941757;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_DUP      = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]      operation;
    logic [31:0]     key;
    logic [31:0]     value;
    logic [BktW-1:0] bucket;
  } req_t;

  typedef enum logic [2:0] {
    FS_IDLE, FS_MUL, FS_DIVSET, FS_DIV, FS_CHECK, FS_PUSH
  } fstate_t;

  typedef enum logic [2:0] {
    BS_IDLE, BS_READ, BS_SCAN, BS_WRITE, BS_OUT
  } bstate_t;
endpackage

### hw/rtl/chkv_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel interfaces
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface chkv_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] key;
  logic [31:0] value;
  modport source (output valid, operation, key, value, input ready);
  modport sink   (input valid, operation, key, value, output ready);
endinterface

interface chkv_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] found_value;
  logic [8:0]  entry_count;
  modport source (output valid, status, found_value, entry_count, input ready);
  modport sink   (input valid, status, found_value, entry_count, output ready);
endinterface

### hw/rtl/chkv_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chkv_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module chkv_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### hw/rtl/chkv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chkv_front: jump hash front end
// Accept a request and iterate jump consistent hash, one round a three-step
// multiply and a bit-serial divide, then hand the request with its bucket on.
// ----------------------------------------------------------------------------
module chkv_front (
  input  logic                   clk,
  input  logic                   rst_n,
  chkv_req_if.sink               in_req,
  output logic                   push,
  output chkv_pkg::req_t         push_req,
  input  logic                   q_full
);
  import chkv_pkg::*;

  fstate_t     state_r, state_nxt;
  logic [1:0]  op_r;
  logic [31:0] key_r, val_r;
  logic [63:0] k_r, k_nxt;
  logic [63:0] lo_r;
  logic [BktW-1:0] b_r, b_nxt;
  logic [31:0] den_r;
  logic [32:0] rem_r, rem_nxt;
  logic [44:0] quo_r;
  logic [5:0]  cnt_r;
  logic [44:0] dividend;
  logic        over;
  logic [1:0]  mstep_r;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  // Dividend (b+1)<<31 is at most 44 bits wide for 4096 buckets.
  assign dividend = {{(44-BktW){1'b0}}, ({1'b0, b_r} + 1'b1)} << 31;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FS_IDLE:   if (in_req.valid) state_nxt = FS_MUL;
      FS_MUL:    if (mstep_r == 2'd2) state_nxt = FS_DIVSET;
      FS_DIVSET: state_nxt = FS_DIV;
      FS_DIV:    if (cnt_r == 6'd0) state_nxt = FS_CHECK;
      FS_CHECK:  state_nxt = over ? FS_PUSH : FS_MUL;
      FS_PUSH:   if (!q_full) state_nxt = FS_IDLE;
      default:   state_nxt = FS_IDLE;
    endcase
  end

  // Low 64 bits of k * JumpMul from three 32x32 partial products:
  // lo*lo in full, then the low halves of the two cross products.
  always_comb begin
    case (mstep_r)
      2'd1: begin
        mul_a = k_r[63:32];
        mul_b = JumpMul[31:0];
      end
      2'd2: begin
        mul_a = k_r[31:0];
        mul_b = JumpMul[63:32];
      end
      default: begin
        mul_a = k_r[31:0];
        mul_b = JumpMul[31:0];
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Jump is at least BUCKETS, stop; else it becomes the next candidate.
  assign over = (quo_r >= 45'(Buckets));
  assign k_nxt = lo_r + 64'd1;
  assign rem_nxt = {rem_r[31:0], dividend[cnt_r]};

  always_ff @(posedge clk) begin
    unique case (state_r)
      FS_IDLE: begin
        op_r    <= in_req.operation;
        key_r   <= in_req.key;
        val_r   <= in_req.value;
        k_r     <= {32'd0, in_req.key};
        b_r     <= '0;
        mstep_r <= '0;
      end
      FS_MUL: begin
        if (mstep_r == 2'd0) lo_r <= mul_p;
        else lo_r <= lo_r + {mul_p[31:0], 32'd0};
        mstep_r <= mstep_r + 2'd1;
      end
      FS_DIVSET: begin
        k_r   <= k_nxt;
        den_r <= k_nxt[63:33] + 32'd1;
        rem_r <= '0;
        quo_r <= '0;
        cnt_r <= 6'd44;
      end
      FS_DIV: begin
        if (rem_nxt >= {1'b0, den_r}) begin
          rem_r <= rem_nxt - {1'b0, den_r};
          quo_r <= {quo_r[43:0], 1'b1};
        end else begin
          rem_r <= rem_nxt;
          quo_r <= {quo_r[43:0], 1'b0};
        end
        cnt_r <= cnt_r - 6'd1;
      end
      FS_CHECK: begin
        if (!over) b_r <= quo_r[BktW-1:0];
        mstep_r <= '0;
      end
      default: ;
    endcase
  end

  assign in_req.ready = (state_r == FS_IDLE);
  assign push = (state_r == FS_PUSH) && !q_full;
  assign push_req = '{operation: op_r, key: key_r, value: val_r, bucket: b_r};
endmodule

### hw/rtl/chkv_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chkv_queue: request queue
// Short FIFO between the hash front end and the bucket back end.
// ----------------------------------------------------------------------------
module chkv_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  chkv_pkg::req_t push_req,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output chkv_pkg::req_t head
);
  import chkv_pkg::*;

  req_t       q_r [QDepth];
  logic       wp_r, rp_r;
  logic [1:0] n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      n_r  <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      n_r <= n_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= push_req;
  end

  assign full  = (n_r == 2'd2);
  assign empty = (n_r == 2'd0);
  assign head  = q_r[rp_r];
endmodule

### hw/rtl/chkv_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chkv_back: bucket back end
// Read the slots of one bucket, match the key, update the store and the
// entry count, and present the result.
// ----------------------------------------------------------------------------
module chkv_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  chkv_pkg::req_t head,
  output logic           pop,
  chkv_rsp_if.source     out_rsp
);
  import chkv_pkg::*;

  bstate_t     state_r, state_nxt;
  req_t        req_r;
  logic [TotalSlots-1:0] valid_r;
  logic [SlotW:0]  idx_r;     // slot being read
  logic [SlotW:0]  sidx_r;    // slot whose data is on the RAM output
  logic        hit_r, emp_r;
  logic [SlotW-1:0] hit_s_r, emp_s_r;
  logic [31:0] hit_v_r;
  logic [8:0]  count_r;
  logic [1:0]  st_r;
  logic [31:0] fv_r;
  logic        we;
  logic [AddrW-1:0] addr;
  logic [31:0] kq, vq;
  logic [AddrW-1:0] base;
  logic [AddrW-1:0] saddr;
  logic        rd_valid;

  assign base = AddrW'(req_r.bucket) * AddrW'(SlotsPerBkt);
  assign saddr = base + AddrW'(sidx_r[SlotW-1:0]);
  assign rd_valid = valid_r[saddr];

  always_comb begin
    we = (state_r == BS_WRITE) && (req_r.operation == OP_INSERT) && !hit_r && emp_r;
    if (state_r == BS_WRITE) addr = base + AddrW'(emp_s_r);
    else addr = base + AddrW'(idx_r[SlotW-1:0]);
  end

  chkv_ram #(.Width(32), .Depth(TotalSlots)) u_key (
    .clk(clk), .we(we), .addr(addr), .wdata(req_r.key), .rdata(kq));
  chkv_ram #(.Width(32), .Depth(TotalSlots)) u_val (
    .clk(clk), .we(we), .addr(addr), .wdata(req_r.value), .rdata(vq));

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BS_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BS_IDLE:  if (!q_empty) state_nxt = BS_READ;
      BS_READ:  state_nxt = BS_SCAN;
      BS_SCAN:  if (sidx_r == (SlotW+1)'(SlotsPerBkt - 1)) state_nxt = BS_WRITE;
      BS_WRITE: state_nxt = BS_OUT;
      BS_OUT:   if (out_rsp.ready) state_nxt = BS_IDLE;
      default:  state_nxt = BS_IDLE;
    endcase
  end

  assign pop = (state_r == BS_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (state_r == BS_WRITE) begin
      if (req_r.operation == OP_INSERT && !hit_r && emp_r) begin
        valid_r[base + AddrW'(emp_s_r)] <= 1'b1;
        count_r <= count_r + 9'd1;
      end else if (req_r.operation == OP_REMOVE && hit_r) begin
        valid_r[base + AddrW'(hit_s_r)] <= 1'b0;
        if (count_r != 9'd0) count_r <= count_r - 9'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      BS_IDLE: begin
        req_r <= head;
        idx_r <= '0;
        hit_r <= 1'b0;
        emp_r <= 1'b0;
      end
      BS_READ: begin
        sidx_r <= idx_r;
        idx_r  <= idx_r + 1'b1;
      end
      BS_SCAN: begin
        if (rd_valid) begin
          if (!hit_r && kq == req_r.key) begin
            hit_r <= 1'b1;
            hit_s_r <= sidx_r[SlotW-1:0];
            hit_v_r <= vq;
          end
        end else if (!emp_r) begin
          emp_r <= 1'b1;
          emp_s_r <= sidx_r[SlotW-1:0];
        end
        sidx_r <= idx_r;
        idx_r  <= idx_r + 1'b1;
      end
      BS_WRITE: begin
        case (req_r.operation) inside
          OP_INSERT: begin
            st_r <= hit_r ? ST_DUP : (emp_r ? ST_DONE : ST_FULL);
            fv_r <= '0;
          end
          OP_SEARCH, OP_REMOVE: begin
            st_r <= hit_r ? ST_DONE : ST_NOTFOUND;
            fv_r <= hit_r ? hit_v_r : '0;
          end
          default: begin
            st_r <= ST_NOTFOUND;
            fv_r <= '0;
          end
        endcase
      end
      default: ;
    endcase
  end

  assign out_rsp.valid = (state_r == BS_OUT);
  assign out_rsp.status = st_r;
  assign out_rsp.found_value = fv_r;
  assign out_rsp.entry_count = count_r;
endmodule

### hw/rtl/chained_hash_key_value_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_key_value_table: key-value table with bounded hash buckets
// A request (insert, search, remove) takes one result. The front end runs
// jump consistent hash; each round is a 64-bit multiply built from three
// 32x32 partial products, a setup state, a bit-serial divide with a 45-bit
// quotient and a check state (rounds grow with the logarithm of the bucket
// count), and the back end then scans and updates its bucket. A two-entry
// queue lets the front end hash the next request while the back end works.
// Keys and data sit in single-port RAMs; slot valid bits are flops cleared
// at reset, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module chained_hash_key_value_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_key,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_found_value,
  output logic [8:0]  out_entry_count
);
  import chkv_pkg::*;

  chkv_req_if req_ch ();
  chkv_rsp_if rsp_ch ();
  logic push, q_full, q_empty, pop;
  req_t push_req, head;

  // Map ports onto the channel interfaces.
  assign req_ch.valid     = in_valid;
  assign req_ch.operation = in_operation;
  assign req_ch.key       = in_key;
  assign req_ch.value     = in_value;
  assign in_ready         = req_ch.ready;
  assign out_valid        = rsp_ch.valid;
  assign rsp_ch.ready     = out_ready;
  assign out_status       = rsp_ch.status;
  assign out_found_value  = rsp_ch.found_value;
  assign out_entry_count  = rsp_ch.entry_count;

  chkv_front u_front (.clk, .rst_n, .in_req(req_ch.sink), .push, .push_req, .q_full);
  chkv_queue u_queue (.clk, .rst_n, .push, .push_req, .full(q_full), .pop,
                      .empty(q_empty), .head);
  chkv_back u_back (.clk, .rst_n, .q_empty, .head, .pop, .out_rsp(rsp_ch.source));
endmodule

### hw/rtl/chkv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chkv_checker: port-level checks
// Watch the result channel and entry count over time.
// ----------------------------------------------------------------------------
module chkv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_found_value,
  input logic [8:0]  out_entry_count
);
  import chkv_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found_value))
    else $error("result dropped while stalled");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_found_value == 32'd0)
    else $error("found value not zero");
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= 9'(TotalSlots))
    else $error("entry count too large");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_entry_count >= 9'(SlotsPerBkt))
    else $error("full bucket with too few entries");
endmodule

bind chained_hash_key_value_table chkv_checker u_chk (.*);

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for chained_hash_key_value_table
// Drives insert, search and remove requests over valid/ready channels with
// random idling on both sides. Every response is checked field by field
// against a bench-side copy of the table that runs its own jump hash. A
// directed table runs first, then random traffic focused on a few crowded
// buckets, a complete fill to 256 entries, and removal of the fill keys.
// ----------------------------------------------------------------------------
module tb_top;
  import chkv_pkg::*;

  localparam int unsigned KeysPerBkt = 8;
  localparam int unsigned IdleLimit  = 20000;
  localparam int unsigned HoldCycles = 400;

  typedef struct {
    op_t         op;
    logic [31:0] key;
    logic [31:0] value;
    bit          typed;   // expected response is written in the row
    status_t     status;
    logic [31:0] found;
    logic [8:0]  count;
  } row_t;

  typedef struct {
    status_t     status;
    logic [31:0] found;
    logic [8:0]  count;
  } resp_t;

  logic clk;
  logic rst_n;

  chkv_req_if rq ();
  chkv_rsp_if rs ();

  chained_hash_key_value_table DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (rq.valid),
    .in_ready        (rq.ready),
    .in_operation    (rq.operation),
    .in_key          (rq.key),
    .in_value        (rq.value),
    .out_valid       (rs.valid),
    .out_ready       (rs.ready),
    .out_status      (rs.status),
    .out_found_value (rs.found_value),
    .out_entry_count (rs.entry_count)
  );

  // Bench copy of the table contents.
  bit          mirror_used  [TotalSlots];
  logic [31:0] mirror_key   [TotalSlots];
  logic [31:0] mirror_value [TotalSlots];
  logic [8:0]  mirror_count;

  // Keys sorted by the bucket they hash to.
  logic [31:0] bucket_keys [Buckets][KeysPerBkt];

  resp_t       pending_resp [$];
  int unsigned error_count;
  bit          hold_request;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Jump consistent hash, fixed-point quotient, as the block computes it.
  function automatic logic [BktW-1:0] bucket_of(logic [31:0] key);
    logic [63:0] k;
    logic [63:0] b;
    logic [63:0] j;
    k = {32'd0, key};
    b = 64'd0;
    j = 64'd0;
    while (j < 64'(Buckets)) begin
      b = j;
      k = k * JumpMul + 64'd1;
      j = ((b + 64'd1) << 31) / ((k >> 33) + 64'd1);
    end
    return b[BktW-1:0];
  endfunction

  // Apply one request to the mirror and return the response it causes.
  function automatic resp_t apply_request(op_t op, logic [31:0] key, logic [31:0] value);
    resp_t r;
    int    base;
    int    hit;
    int    free_slot;
    base = int'(bucket_of(key)) * SlotsPerBkt;
    hit = -1;
    free_slot = -1;
    r.status = ST_NOTFOUND;
    r.found = 32'd0;
    for (int i = 0; i < SlotsPerBkt; i++) begin
      if (mirror_used[base + i]) begin
        if (hit < 0 && mirror_key[base + i] == key) hit = base + i;
      end else if (free_slot < 0) begin
        free_slot = base + i;
      end
    end
    case (op)
      OP_INSERT: begin
        if (hit >= 0) begin
          r.status = ST_DUP;
        end else if (free_slot < 0) begin
          r.status = ST_FULL;
        end else begin
          mirror_used[free_slot] = 1'b1;
          mirror_key[free_slot] = key;
          mirror_value[free_slot] = value;
          mirror_count++;
          r.status = ST_DONE;
        end
      end
      OP_SEARCH: begin
        if (hit >= 0) begin
          r.status = ST_DONE;
          r.found = mirror_value[hit];
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          r.status = ST_DONE;
          r.found = mirror_value[hit];
          mirror_used[hit] = 1'b0;
          if (mirror_count > 0) mirror_count--;
        end
      end
      default: ;
    endcase
    r.count = mirror_count;
    return r;
  endfunction

  // Offer one request after a random gap; queue its expected response once
  // the block takes it. Call right after a rising edge.
  task automatic send_request(row_t rw);
    int unsigned gap;
    resp_t       r;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      rq.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rq.valid <= 1'b1;
    rq.operation <= rw.op;
    rq.key <= rw.key;
    rq.value <= rw.value;
    @(posedge clk);
    while (!rq.ready) @(posedge clk);
    r = apply_request(rw.op, rw.key, rw.value);
    if (rw.typed) begin
      r.status = rw.status;
      r.found = rw.found;
      r.count = rw.count;
    end
    pending_resp.push_back(r);
  endtask

  function automatic row_t plain_row(op_t op, logic [31:0] key, logic [31:0] value);
    row_t rw;
    rw.op = op;
    rw.key = key;
    rw.value = value;
    rw.typed = 1'b0;
    rw.status = ST_DONE;
    rw.found = 32'd0;
    rw.count = 9'd0;
    return rw;
  endfunction

  function automatic row_t typed_row(op_t op, logic [31:0] key, logic [31:0] value,
                                     status_t st, logic [31:0] found, logic [8:0] count);
    row_t rw;
    rw = plain_row(op, key, value);
    rw.typed = 1'b1;
    rw.status = st;
    rw.found = found;
    rw.count = count;
    return rw;
  endfunction

  // Random request: mostly keys from a few crowded buckets so that hits,
  // duplicates and full buckets are common; some keys fully random.
  function automatic row_t random_row(int unsigned hot0, int unsigned hot1,
                                      int unsigned hot2, int unsigned hot3);
    int unsigned pick;
    int unsigned bkt;
    op_t         op;
    logic [31:0] key;
    pick = $urandom_range(0, 99);
    if (pick < 40) op = OP_INSERT;
    else if (pick < 65) op = OP_SEARCH;
    else if (pick < 95) op = OP_REMOVE;
    else op = OP_NONE;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: bkt = hot0;
      1: bkt = hot1;
      2: bkt = hot2;
      default: bkt = hot3;
    endcase
    if (pick < 85) key = bucket_keys[bkt][$urandom_range(0, KeysPerBkt - 1)];
    else if (pick < 95) key = bucket_keys[$urandom_range(0, Buckets - 1)][$urandom_range(0, 7)];
    else key = $urandom;
    return plain_row(op, key, $urandom);
  endfunction

  // Drop the request line and hold until every response has come back.
  task automatic wait_drained();
    rq.valid <= 1'b0;
    while (pending_resp.size() > 0) @(posedge clk);
  endtask

  task automatic random_burst(int unsigned items, bit with_hold);
    int unsigned h [4];
    for (int n = 0; n < items; n++) begin
      // Move the crowded buckets now and then.
      if (n % 100 == 0) begin
        foreach (h[i]) h[i] = $urandom_range(0, Buckets - 1);
      end
      if (with_hold && n == items / 2) hold_request = 1'b1;
      send_request(random_row(h[0], h[1], h[2], h[3]));
    end
  endtask

  // Response side: random back-pressure per response, plus one long hold.
  initial begin
    int unsigned stall;
    rs.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = $urandom_range(0, 3);
      if (hold_request) begin
        hold_request = 1'b0;
        stall = HoldCycles;
      end
      if (stall > 0) begin
        rs.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rs.ready <= 1'b1;
      @(posedge clk);
      while (!rs.valid) @(posedge clk);
    end
  end

  // Compare each response with the oldest expectation.
  always @(posedge clk) begin
    resp_t want;
    if (rst_n && rs.valid && rs.ready) begin
      if (pending_resp.size() == 0) begin
        $display("%0t: response with nothing pending: status %0d value %h count %0d",
                 $time, rs.status, rs.found_value, rs.entry_count);
        error_count++;
      end else begin
        want = pending_resp.pop_front();
        if (rs.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, rs.status);
          error_count++;
        end
        if (rs.found_value !== want.found) begin
          $display("%0t: found_value expected %h actual %h", $time, want.found,
                   rs.found_value);
          error_count++;
        end
        if (rs.entry_count !== want.count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                   rs.entry_count);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no handshake happens for too long.
  initial begin
    int unsigned idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((rq.valid && rq.ready) || (rs.valid && rs.ready)) idle = 0;
      else idle++;
      if (idle >= IdleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    row_t        directed [$];
    int unsigned fill_cnt [Buckets];
    int unsigned filled;
    int unsigned order [Buckets];
    logic [31:0] probe;
    logic [31:0] kb [KeysPerBkt];
    int unsigned b0;
    int unsigned bk;

    rst_n = 1'b0;
    rq.valid = 1'b0;
    rq.operation = OP_SEARCH;
    rq.key = 32'd0;
    rq.value = 32'd0;
    error_count = 0;
    hold_request = 1'b0;
    mirror_count = 9'd0;
    foreach (mirror_used[i]) begin
      mirror_used[i] = 1'b0;
      mirror_key[i] = 32'd0;
      mirror_value[i] = 32'd0;
    end

    // Sort keys by bucket; spread the bits of the scanned index.
    foreach (fill_cnt[i]) fill_cnt[i] = 0;
    filled = 0;
    for (int unsigned i = 0; filled < Buckets; i++) begin
      probe = (i == 0) ? 32'd0 : (i * 32'h9E3779B1) ^ (i << 7);
      bk = bucket_of(probe);
      if (fill_cnt[bk] < KeysPerBkt) begin
        bucket_keys[bk][fill_cnt[bk]] = probe;
        fill_cnt[bk]++;
        if (fill_cnt[bk] == KeysPerBkt) filled++;
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, extremes, duplicate, full bucket, slot reuse.
    b0 = bucket_of(32'd0);
    foreach (kb[i]) kb[i] = bucket_keys[b0][i];
    directed.push_back(typed_row(OP_SEARCH, 32'd0, 32'd0, ST_NOTFOUND, 32'd0, 9'd0));
    directed.push_back(typed_row(OP_REMOVE, 32'hFFFFFFFF, 32'hFFFFFFFF,
                                 ST_NOTFOUND, 32'd0, 9'd0));
    directed.push_back(typed_row(OP_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF,
                                 ST_NOTFOUND, 32'd0, 9'd0));
    directed.push_back(typed_row(OP_INSERT, kb[0], 32'hFFFFFFFF, ST_DONE, 32'd0, 9'd1));
    directed.push_back(typed_row(OP_INSERT, kb[0], 32'h12345678, ST_DUP, 32'd0, 9'd1));
    directed.push_back(typed_row(OP_SEARCH, kb[0], 32'd0, ST_DONE, 32'hFFFFFFFF, 9'd1));
    directed.push_back(typed_row(OP_INSERT, kb[1], 32'hA5A5A5A5, ST_DONE, 32'd0, 9'd2));
    directed.push_back(typed_row(OP_INSERT, kb[2], 32'h5A5A5A5A, ST_DONE, 32'd0, 9'd3));
    directed.push_back(typed_row(OP_INSERT, kb[3], 32'd0, ST_DONE, 32'd0, 9'd4));
    directed.push_back(typed_row(OP_INSERT, kb[4], 32'h0000BEEF, ST_FULL, 32'd0, 9'd4));
    directed.push_back(typed_row(OP_REMOVE, kb[4], 32'd0, ST_NOTFOUND, 32'd0, 9'd4));
    directed.push_back(typed_row(OP_REMOVE, kb[1], 32'd0, ST_DONE, 32'hA5A5A5A5, 9'd3));
    directed.push_back(typed_row(OP_SEARCH, kb[1], 32'd0, ST_NOTFOUND, 32'd0, 9'd3));
    // Lowest free slot is reused: the next insert takes the freed slot.
    directed.push_back(typed_row(OP_INSERT, kb[4], 32'h0000BEEF, ST_DONE, 32'd0, 9'd4));
    directed.push_back(typed_row(OP_SEARCH, kb[4], 32'd0, ST_DONE, 32'h0000BEEF, 9'd4));
    directed.push_back(typed_row(OP_NONE, kb[4], 32'd0, ST_NOTFOUND, 32'd0, 9'd4));
    directed.push_back(plain_row(OP_INSERT, 32'hFFFFFFFF, 32'd0));
    directed.push_back(plain_row(OP_SEARCH, 32'hFFFFFFFF, 32'hFFFFFFFF));
    directed.push_back(plain_row(OP_REMOVE, 32'hFFFFFFFF, 32'd0));
    directed.push_back(plain_row(OP_REMOVE, kb[0], 32'd0));
    directed.push_back(plain_row(OP_REMOVE, kb[2], 32'd0));
    directed.push_back(plain_row(OP_REMOVE, kb[3], 32'd0));
    directed.push_back(plain_row(OP_REMOVE, kb[4], 32'd0));
    foreach (directed[i]) send_request(directed[i]);

    random_burst(500, 1'b0);

    // Pause until the block has answered everything, then fill every slot.
    wait_drained();
    foreach (order[i]) order[i] = i;
    order.shuffle();
    for (int s = 0; s < SlotsPerBkt + 2; s++) begin
      foreach (order[i]) begin
        send_request(plain_row(OP_INSERT, bucket_keys[order[i]][s], $urandom));
        if (s >= SlotsPerBkt && i >= 3) break;
      end
    end
    // Remove the fill keys again, then churn with a long response hold mid-way.
    for (int s = 0; s < KeysPerBkt; s++) begin
      foreach (order[i]) begin
        send_request(plain_row(OP_REMOVE, bucket_keys[order[i]][s], 32'd0));
        if (s >= SlotsPerBkt && i >= 3) break;
      end
    end
    random_burst(500, 1'b1);

    rq.valid <= 1'b0;
    wait_drained();
    repeat (60) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

### filelist.f
hw/rtl/chkv_pkg.sv
hw/rtl/chkv_if.sv
hw/rtl/chkv_ram.sv
hw/rtl/chkv_front.sv
hw/rtl/chkv_queue.sv
hw/rtl/chkv_back.sv
hw/rtl/chained_hash_key_value_table.sv
hw/rtl/chkv_checker.sv
bench/tb_top.sv
